// ===== rtl/bctc_pkg.sv =====
// Package for the block cache tag controller: payload types, codes and defaults.
// No dependencies.
`default_nettype none
package bctc_pkg;
    localparam int SLOTS_DEF = 16;
    localparam logic [4:0] DIRTY_LIMIT_RESET = 5'd12;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_FILL   = 2'd1;
    localparam logic [1:0] CMD_WRITE  = 2'd2;
    localparam logic [1:0] CMD_FLUSH  = 2'd3;

    localparam logic [2:0] KIND_HIT   = 3'd0;
    localparam logic [2:0] KIND_MISS  = 3'd1;
    localparam logic [2:0] KIND_FILL  = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_WB    = 3'd4;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] block;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic        take_data;
        logic [31:0] wb_block;
        logic        run_start;
        logic        last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FLUSH,
        ST_FIN
    } state_t;
endpackage
`default_nettype wire

// ===== rtl/block_cache_tag_controller_core.sv =====
// Top level of the block cache tag controller.
// Depends on bctc_pkg and bctc_ram.
`default_nettype none
// Tag, age and dirty bookkeeping for a write-back block cache whose payload memory
// lies outside. A transaction is taken at a rising edge with start high and busy
// low. Every result is on the result port for exactly one cycle with strobe high,
// and the receiver cannot stall it. Tags and ages live in two RAMs with a registered
// read, so each command walks all slots through the read port. A lookup, fill or
// write that needs no flush answers in the last cycle that it holds busy, and a new
// command is taken only once busy has fallen. A flush finds each write-back entry
// by one pass over the tag RAM (smallest dirty tag above the previous one) and
// emits it in the last cycle of that pass. One more pass that finds nothing and the
// FIN state, which cleans every slot, end it. A write that must flush first
// rescans the slots afterward.
// Valid and dirty bits are flip-flops cleared by reset; no clearing pass.
module block_cache_tag_controller_core #(
    parameter int SLOTS = bctc_pkg::SLOTS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire bctc_pkg::cmd_t   cmd,
    output logic                  busy,
    output logic                  strobe,
    output bctc_pkg::result_t     result,
    input  wire logic             cfg_we,
    input  wire logic [4:0]       cfg_wdata
);
    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    bctc_pkg::state_t state_reg, state_next;
    logic [4:0]       limit_reg;
    logic [31:0]      counter_reg;
    logic [SLOTS-1:0] valid_reg, dirty_reg;
    bctc_pkg::cmd_t   cmd_reg;

    // Scan bookkeeping.
    logic [AW:0]  raddr_reg;    // read address issued
    logic [AW:0]  ridx_reg;     // index whose data is returning
    logic         rvld_reg;
    logic         hit_reg;
    logic [AW-1:0] hit_slot_reg;
    logic         vic_reg;
    logic [AW-1:0] vic_slot_reg;
    logic [31:0]  vic_age_reg;
    logic         inv_reg;
    logic [AW-1:0] inv_slot_reg;
    // Flush bookkeeping.
    logic         pf_reg;       // an entry was emitted before
    logic [31:0]  prev_reg;
    logic         fbest_reg;
    logic [AW-1:0] fslot_reg;
    logic [31:0]  ftag_reg;
    logic         pend_reg;     // command after flush is a write
    logic [CW-1:0] emitted_reg; // entries listed so far in this flush

    logic [31:0]  tag_rd, age_rd;
    logic         tag_we, age_we;
    logic [AW-1:0] tag_wa, age_wa;
    logic [31:0]  tag_wd;
    logic [AW-1:0] raddr;

    logic [CW-1:0] ndirty;
    logic [CW-1:0] nlist;
    logic [AW-1:0] ri;
    logic          scan_done, pass_done;
    logic          found;
    logic [AW-1:0] place_slot;
    logic [AW-1:0] wr_slot;
    logic          can_place;
    logic          need_flush;
    logic          flush_now;
    logic          cand;
    logic          accept;
    logic          walking;
    logic          restart;
    logic          scan_init;
    logic          flush_init;

    assign raddr = raddr_reg[AW-1:0];

    bctc_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_tag (
        .clk(clk), .we(tag_we), .waddr(tag_wa), .wdata(tag_wd),
        .raddr(raddr), .rdata(tag_rd)
    );
    bctc_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_age (
        .clk(clk), .we(age_we), .waddr(age_wa), .wdata(counter_reg),
        .raddr(raddr), .rdata(age_rd)
    );

    // Dirty slots, and dirty slots that a flush lists.
    always_comb
    begin
        ndirty = '0;
        nlist = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            ndirty = ndirty + CW'(dirty_reg[i]);
            nlist = nlist + CW'(dirty_reg[i] & valid_reg[i]);
        end
    end

    assign ri = ridx_reg[AW-1:0];
    assign scan_done = rvld_reg && (ridx_reg == (AW+1)'(SLOTS - 1));
    assign pass_done = scan_done;

    // Decision after the scan.
    always_comb
    begin
        found = hit_reg;
        can_place = hit_reg || inv_reg || vic_reg;
        place_slot = hit_reg ? hit_slot_reg : (inv_reg ? inv_slot_reg : vic_slot_reg);
        wr_slot = can_place ? place_slot : '0;
        need_flush = (32'(ndirty) >= 32'(limit_reg)) ||
                     (!hit_reg && (ndirty == CW'(SLOTS)));
        flush_now = (cmd_reg.command == bctc_pkg::CMD_WRITE) && need_flush && !pend_reg;
    end

    // Candidate for the flush pass: smallest dirty tag above the previous one.
    assign cand = rvld_reg && dirty_reg[ri] && valid_reg[ri] &&
                  (!pf_reg || tag_rd > prev_reg) && (!fbest_reg || tag_rd < ftag_reg);

    // Events that restart the read walk or clear the bookkeeping.
    assign accept = (state_reg == bctc_pkg::ST_IDLE) && start;
    assign walking = (state_reg == bctc_pkg::ST_SCAN) || (state_reg == bctc_pkg::ST_FLUSH);
    assign flush_init = accept || ((state_reg == bctc_pkg::ST_DECIDE) && flush_now);
    assign scan_init = accept || ((state_reg == bctc_pkg::ST_FIN) && pend_reg);
    assign restart = flush_init || scan_init ||
                     ((state_reg == bctc_pkg::ST_FLUSH) && pass_done);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bctc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (cmd.command == bctc_pkg::CMD_FLUSH) ?
                                 bctc_pkg::ST_FLUSH : bctc_pkg::ST_SCAN;
                end
            end
            bctc_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = bctc_pkg::ST_DECIDE;
                end
            end
            bctc_pkg::ST_DECIDE:
            begin
                state_next = flush_now ? bctc_pkg::ST_FLUSH : bctc_pkg::ST_IDLE;
            end
            bctc_pkg::ST_FLUSH:
            begin
                if (pass_done && !(fbest_reg || cand))
                begin
                    state_next = bctc_pkg::ST_FIN;
                end
            end
            bctc_pkg::ST_FIN:
            begin
                // A pending write rescans, since every slot is clean now.
                state_next = pend_reg ? bctc_pkg::ST_SCAN : bctc_pkg::ST_IDLE;
            end
            default: state_next = bctc_pkg::ST_IDLE;
        endcase
    end

    // Outputs and memory writes.
    always_comb
    begin
        busy = (state_reg != bctc_pkg::ST_IDLE);
        strobe = 1'b0;
        result = '0;
        tag_we = 1'b0;
        age_we = 1'b0;
        tag_wa = wr_slot;
        age_wa = wr_slot;
        tag_wd = cmd_reg.block;
        case (state_reg)
            bctc_pkg::ST_DECIDE:
            begin
                case (cmd_reg.command)
                    bctc_pkg::CMD_LOOKUP:
                    begin
                        strobe = 1'b1;
                        result.last = 1'b1;
                        result.kind = found ? bctc_pkg::KIND_HIT : bctc_pkg::KIND_MISS;
                        result.slot = found ? 4'(hit_slot_reg) : 4'd0;
                        age_we = found;
                    end
                    bctc_pkg::CMD_FILL:
                    begin
                        strobe = 1'b1;
                        result.last = 1'b1;
                        result.kind = bctc_pkg::KIND_FILL;
                        result.slot = 4'(wr_slot);
                        result.take_data = can_place &&
                                           !(found && dirty_reg[hit_slot_reg]);
                        age_we = can_place;
                        tag_we = can_place && !found;
                    end
                    bctc_pkg::CMD_WRITE:
                    begin
                        if (!flush_now)
                        begin
                            strobe = 1'b1;
                            result.last = 1'b1;
                            result.kind = bctc_pkg::KIND_WRITE;
                            result.take_data = 1'b1;
                            result.slot = 4'(wr_slot);
                            age_we = 1'b1;
                            tag_we = !found;
                        end
                    end
                    default: ;
                endcase
            end
            bctc_pkg::ST_FLUSH:
            begin
                if (pass_done && (fbest_reg || cand))
                begin
                    strobe = 1'b1;
                    result.kind = bctc_pkg::KIND_WB;
                    result.slot = 4'(cand ? ri : fslot_reg);
                    result.wb_block = cand ? tag_rd : ftag_reg;
                    result.run_start = !pf_reg ||
                        (result.wb_block != prev_reg + 32'd1);
                    // Only a flush command marks its final entry.
                    result.last = !pend_reg && ((emitted_reg + CW'(1)) == nlist);
                end
            end
            default: ;
        endcase
    end

    // Control and bookkeeping registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bctc_pkg::ST_IDLE;
            limit_reg <= bctc_pkg::DIRTY_LIMIT_RESET;
            counter_reg <= '0;
            valid_reg <= '0;
            dirty_reg <= '0;
            cmd_reg <= '0;
            pend_reg <= 1'b0;
            raddr_reg <= '0;
            ridx_reg <= '0;
            rvld_reg <= 1'b0;
            hit_reg <= 1'b0;
            hit_slot_reg <= '0;
            vic_reg <= 1'b0;
            vic_slot_reg <= '0;
            vic_age_reg <= '0;
            inv_reg <= 1'b0;
            inv_slot_reg <= '0;
            pf_reg <= 1'b0;
            prev_reg <= '0;
            fbest_reg <= 1'b0;
            fslot_reg <= '0;
            ftag_reg <= '0;
            emitted_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end

            // Command capture; a lookup bumps the access counter.
            if (accept)
            begin
                cmd_reg <= cmd;
                pend_reg <= 1'b0;
                if (cmd.command == bctc_pkg::CMD_LOOKUP)
                begin
                    counter_reg <= counter_reg + 32'd1;
                end
            end
            else if (state_reg == bctc_pkg::ST_DECIDE && flush_now)
            begin
                pend_reg <= 1'b1;
            end

            // Walk read addresses; data returns in the next cycle.
            if (restart)
            begin
                raddr_reg <= '0;
                rvld_reg <= 1'b0;
            end
            else if (walking)
            begin
                rvld_reg <= (raddr_reg < (AW+1)'(SLOTS));
                raddr_reg <= (raddr_reg < (AW+1)'(SLOTS)) ?
                             raddr_reg + (AW+1)'(1) : raddr_reg;
            end
            if (walking)
            begin
                ridx_reg <= raddr_reg;
            end

            // Hit, first empty slot and oldest clean slot.
            if (scan_init)
            begin
                hit_reg <= 1'b0;
                vic_reg <= 1'b0;
                inv_reg <= 1'b0;
            end
            else if (state_reg == bctc_pkg::ST_SCAN && rvld_reg)
            begin
                if (!hit_reg && valid_reg[ri] && tag_rd == cmd_reg.block)
                begin
                    hit_reg <= 1'b1;
                    hit_slot_reg <= ri;
                end
                if (!inv_reg && !valid_reg[ri])
                begin
                    inv_reg <= 1'b1;
                    inv_slot_reg <= ri;
                end
                if (valid_reg[ri] && !dirty_reg[ri] && (!vic_reg || age_rd < vic_age_reg))
                begin
                    vic_reg <= 1'b1;
                    vic_slot_reg <= ri;
                    vic_age_reg <= age_rd;
                end
            end

            // Best candidate of the current flush pass.
            if (restart)
            begin
                fbest_reg <= 1'b0;
            end
            else if (state_reg == bctc_pkg::ST_FLUSH && cand)
            begin
                fbest_reg <= 1'b1;
                fslot_reg <= ri;
                ftag_reg <= tag_rd;
            end

            // Previous entry of the flush, for ordering and run starts.
            if (flush_init)
            begin
                pf_reg <= 1'b0;
                emitted_reg <= '0;
            end
            else if (state_reg == bctc_pkg::ST_FLUSH && strobe)
            begin
                pf_reg <= 1'b1;
                prev_reg <= result.wb_block;
                emitted_reg <= emitted_reg + CW'(1);
            end

            // Valid and dirty updates.
            if (state_reg == bctc_pkg::ST_FIN)
            begin
                dirty_reg <= '0;
            end
            else if (state_reg == bctc_pkg::ST_DECIDE && strobe)
            begin
                if (cmd_reg.command == bctc_pkg::CMD_FILL && can_place && !found)
                begin
                    valid_reg[wr_slot] <= 1'b1;
                    dirty_reg[wr_slot] <= 1'b0;
                end
                else if (cmd_reg.command == bctc_pkg::CMD_WRITE)
                begin
                    valid_reg[wr_slot] <= 1'b1;
                    dirty_reg[wr_slot] <= 1'b1;
                end
            end
        end
    end

    // Results appear only while a command is in progress.
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy);
    // Result ports rest at zero between results.
    a_quiet_result: assert property (@(posedge clk) disable iff (!rst_n)
        !strobe |-> (result == '0));
    // A dirty slot always holds a block.
    a_dirty_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (dirty_reg & ~valid_reg) == '0);
    // The strobe is never unknown.
    a_strobe_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(strobe));
endmodule
`default_nettype wire

// ===== rtl/bctc_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bctc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== tb/tb_block_cache_tag_controller_core.sv =====
// Testbench for the block cache tag controller: a scoreboard class predicts each
// command's results and checks them as they appear. Depends on bctc_pkg and the core.
`timescale 1ns / 100ps

module tb_block_cache_tag_controller_core;
    localparam int NSLOT = bctc_pkg::SLOTS_DEF;

    // Predicts the controller's answers and holds them until they come out.
    class cache_scoreboard;
        logic [31:0]        tag_q[NSLOT];
        bit                 valid_q[NSLOT];
        logic [31:0]        age_q[NSLOT];
        bit                 dirty_q[NSLOT];
        logic [31:0]        access_cnt;
        logic [4:0]         dirty_limit;
        bctc_pkg::result_t  pending_q[$];
        int                 errors;
        int                 checked;
        int                 wb_seen;

        function new();
            for (int i = 0; i < NSLOT; i++)
            begin
                tag_q[i] = '0;
                valid_q[i] = 0;
                age_q[i] = '0;
                dirty_q[i] = 0;
            end
            access_cnt = '0;
            dirty_limit = bctc_pkg::DIRTY_LIMIT_RESET;
            errors = 0;
            checked = 0;
            wb_seen = 0;
        endfunction

        function void set_limit(logic [4:0] v);
            dirty_limit = v;
        endfunction

        function void push(logic [2:0] kind, int slot, bit take, logic [31:0] wb,
                           bit rs, bit last);
            bctc_pkg::result_t r;
            r.kind = kind;
            r.slot = slot[3:0];
            r.take_data = take;
            r.wb_block = wb;
            r.run_start = rs;
            r.last = last;
            pending_q.push_back(r);
        endfunction

        function int find_slot(logic [31:0] b);
            for (int i = 0; i < NSLOT; i++)
                if (valid_q[i] && tag_q[i] == b)
                    return i;
            return -1;
        endfunction

        function int pick_victim();
            int best;
            best = -1;
            for (int i = 0; i < NSLOT; i++)
                if (!valid_q[i])
                    return i;
            for (int i = 0; i < NSLOT; i++)
                if (!dirty_q[i] && (best < 0 || age_q[i] < age_q[best]))
                    best = i;
            return best;
        endfunction

        // Emits write-back entries in ascending block order, then cleans every slot.
        function int write_back_all();
            int order[$];
            int n;
            int j;
            int v;
            logic [31:0] prev;
            for (int i = 0; i < NSLOT; i++)
                if (dirty_q[i] && valid_q[i])
                    order.push_back(i);
            n = order.size();
            for (int i = 1; i < n; i++)
            begin
                v = order[i];
                j = i - 1;
                while (j >= 0 && tag_q[order[j]] > tag_q[v])
                begin
                    order[j + 1] = order[j];
                    j--;
                end
                order[j + 1] = v;
            end
            for (int i = 0; i < n; i++)
            begin
                push(bctc_pkg::KIND_WB, order[i], 0, tag_q[order[i]],
                     (i == 0) || (tag_q[order[i]] != prev + 32'd1), 0);
                prev = tag_q[order[i]];
            end
            for (int i = 0; i < NSLOT; i++)
                dirty_q[i] = 0;
            return n;
        endfunction

        // Notes an accepted command transaction and queues its expected results.
        function void note_command(bctc_pkg::cmd_t c);
            int s;
            int nd;
            int k;
            case (c.command)
                bctc_pkg::CMD_LOOKUP:
                begin
                    access_cnt = access_cnt + 32'd1;
                    s = find_slot(c.block);
                    if (s >= 0)
                    begin
                        age_q[s] = access_cnt;
                        push(bctc_pkg::KIND_HIT, s, 0, '0, 0, 1);
                    end
                    else
                        push(bctc_pkg::KIND_MISS, 0, 0, '0, 0, 1);
                end
                bctc_pkg::CMD_FILL:
                begin
                    s = find_slot(c.block);
                    if (s >= 0)
                    begin
                        age_q[s] = access_cnt;
                        push(bctc_pkg::KIND_FILL, s, !dirty_q[s], '0, 0, 1);
                    end
                    else
                    begin
                        s = pick_victim();
                        if (s < 0)
                            push(bctc_pkg::KIND_FILL, 0, 0, '0, 0, 1);
                        else
                        begin
                            tag_q[s] = c.block;
                            valid_q[s] = 1;
                            dirty_q[s] = 0;
                            age_q[s] = access_cnt;
                            push(bctc_pkg::KIND_FILL, s, 1, '0, 0, 1);
                        end
                    end
                end
                bctc_pkg::CMD_WRITE:
                begin
                    nd = 0;
                    for (int i = 0; i < NSLOT; i++)
                        nd += dirty_q[i];
                    s = find_slot(c.block);
                    if (nd >= dirty_limit || (s < 0 && nd >= NSLOT))
                        k = write_back_all();
                    if (s < 0)
                    begin
                        s = pick_victim();
                        if (s < 0)
                            s = 0;
                        tag_q[s] = c.block;
                        valid_q[s] = 1;
                    end
                    age_q[s] = access_cnt;
                    dirty_q[s] = 1;
                    push(bctc_pkg::KIND_WRITE, s, 1, '0, 0, 1);
                end
                default:
                begin
                    k = write_back_all();
                    if (k > 0)
                        pending_q[pending_q.size() - 1].last = 1;
                end
            endcase
        endfunction

        // Compares one strobed result with the oldest expectation.
        function void check_result(bctc_pkg::result_t r);
            bctc_pkg::result_t e;
            checked++;
            if (r.kind == bctc_pkg::KIND_WB)
                wb_seen++;
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result kind=%0d slot=%0d wb=%h",
                         $time, r.kind, r.slot, r.wb_block);
                return;
            end
            e = pending_q.pop_front();
            if (r.kind !== e.kind || r.slot !== e.slot || r.take_data !== e.take_data ||
                r.wb_block !== e.wb_block || r.run_start !== e.run_start ||
                r.last !== e.last)
            begin
                errors++;
                $display("%0t: mismatch expected kind=%0d slot=%0d take=%b wb=%h rs=%b last=%b",
                         $time, e.kind, e.slot, e.take_data, e.wb_block, e.run_start, e.last);
                $display("%0t:          actual   kind=%0d slot=%0d take=%b wb=%h rs=%b last=%b",
                         $time, r.kind, r.slot, r.take_data, r.wb_block, r.run_start, r.last);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    bctc_pkg::cmd_t     cmd;
    logic               busy;
    logic               strobe;
    bctc_pkg::result_t  result;
    logic               cfg_we;
    logic [4:0]         cfg_wdata;

    cache_scoreboard sb;
    bit          idle_on;
    int          sent;
    logic [31:0] base_blk;

    block_cache_tag_controller_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .cmd(cmd),
        .busy(busy),
        .strobe(strobe),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // Clock generation.
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Result monitor: every strobed result is checked at the edge that ends it.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check_result(result);
    end

    // Sends one command transaction, with a random idle gap ahead of it.
    task automatic send(logic [1:0] op, logic [31:0] blk);
        bctc_pkg::cmd_t c;
        int gap;
        c.command = op;
        c.block = blk;
        gap = (idle_on && $urandom_range(0, 99) < 24) ? $urandom_range(1, 5) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_command(c);
        sent++;
    endtask

    // Waits until all expected results are out and the block has gone quiet.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0 || busy)
            @(posedge clk);
        repeat (NSLOT * 4) @(posedge clk);
    endtask

    task automatic write_limit(logic [4:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_limit(v);
    endtask

    // Picks a block: mostly near a base so hits and contiguous runs occur.
    function automatic logic [31:0] pick_block();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return $urandom();
        else if (r < 10)
            return 32'hFFFF_FFFF - $urandom_range(0, 2);
        else if (r < 12)
            return $urandom_range(0, 2);
        return base_blk + $urandom_range(0, 23);
    endfunction

    task automatic random_phase(int count, bit with_pause);
        int r;
        logic [1:0] op;
        base_blk = $urandom();
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            op = (r < 28) ? bctc_pkg::CMD_LOOKUP : (r < 52) ? bctc_pkg::CMD_FILL :
                 (r < 92) ? bctc_pkg::CMD_WRITE : bctc_pkg::CMD_FLUSH;
            if (with_pause && i == count / 2)
                drain();
            send(op, pick_block());
        end
    endtask

    // Run-time limit.
    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        sb = new();
        idle_on = 1;
        sent = 0;
        base_blk = '0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: hit, miss, fills of clean and dirty blocks, extreme blocks, flushes.
        send(bctc_pkg::CMD_LOOKUP, 32'h0);
        send(bctc_pkg::CMD_FILL, 32'h0);
        send(bctc_pkg::CMD_LOOKUP, 32'h0);
        send(bctc_pkg::CMD_FILL, 32'h0);
        send(bctc_pkg::CMD_WRITE, 32'h0);
        send(bctc_pkg::CMD_FILL, 32'h0);
        send(bctc_pkg::CMD_WRITE, 32'hFFFF_FFFF);
        send(bctc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF);
        send(bctc_pkg::CMD_FLUSH, 32'h0);
        send(bctc_pkg::CMD_FLUSH, 32'hFFFF_FFFF);

        // Directed: fill the cache with dirty blocks, then fill and write when all are dirty.
        write_limit(5'd16);
        for (int i = 0; i < NSLOT; i++)
            send(bctc_pkg::CMD_WRITE, (i < 8) ? 32'd100 + i : 32'd200 + 2 * i);
        send(bctc_pkg::CMD_FILL, 32'd7);
        send(bctc_pkg::CMD_WRITE, 32'd999);

        // Random phases over several limits; one phase runs with no idle gaps.
        write_limit(5'd1);
        random_phase(50, 0);
        write_limit(5'd16);
        idle_on = 0;
        random_phase(50, 1);
        idle_on = 1;
        write_limit(5'd5);
        random_phase(50, 0);
        write_limit(5'($urandom_range(1, 16)));
        random_phase(50, 0);
        write_limit(5'd12);
        random_phase(60, 0);

        drain();
        $display("Sent %0d commands, checked %0d results including %0d write-back entries.",
                 sent, sb.checked, sb.wb_seen);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
